>>> rtl/sfbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfbi_pkg;

   localparam int TAPS     = 8;
   localparam int OUT_EDGE = 8;
   localparam int SHIFT    = 6;
   localparam int EDGE     = OUT_EDGE + TAPS - 1;

   localparam int SAMPLE_W = 8;
   localparam int TAP_W    = 8;
   localparam int HVAL_W   = 16;
   localparam int PIX_W    = 8;
   localparam int CNT_W    = $clog2(EDGE);
   localparam int COEF_W   = 64;
   localparam int CSR_IDX_W = 8;

   // signed tap times zero-extended sample
   localparam int HPROD_W = TAP_W + SAMPLE_W + 1;
   localparam int HSUM_W  = HPROD_W + $clog2(TAPS);
   localparam int VPROD_W = TAP_W + HVAL_W;
   localparam int VSUM_W  = VPROD_W + $clog2(TAPS);

   localparam int PIX_MAX = 255;

   localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(64'h0000_0000_4000_0000);

   localparam logic [CSR_IDX_W-1:0] CSR_H_COEFFS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_V_COEFFS = CSR_IDX_W'(1);

   localparam logic signed [HSUM_W-1:0] HVAL_MAX = HSUM_W'((1 << (HVAL_W - 1)) - 1);
   localparam logic signed [HSUM_W-1:0] HVAL_MIN = HSUM_W'(-(1 << (HVAL_W - 1)));
   localparam logic signed [VSUM_W-1:0] PIX_MAX_S = VSUM_W'(PIX_MAX);

   // per-word flags that travel down the pipeline
   typedef struct packed {
      logic hv;    // word completes a horizontal result
      logic out;   // word completes an output pixel
      logic last;  // last pixel of the block
   } sfbi_tag_type;

   function automatic logic signed [HVAL_W-1:0] sat_hval(input logic signed [HSUM_W-1:0] v);
      logic signed [HSUM_W-1:0] s;
      s = v >>> SHIFT;
      if (s > HVAL_MAX) begin
         s = HVAL_MAX;
      end else if (s < HVAL_MIN) begin
         s = HVAL_MIN;
      end
      return HVAL_W'(s);
   endfunction

   function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [VSUM_W-1:0] v);
      logic signed [VSUM_W-1:0] s;
      s = v >>> SHIFT;
      if (s < 0) begin
         s = '0;
      end else if (s > PIX_MAX_S) begin
         s = PIX_MAX_S;
      end
      return PIX_W'(s);
   endfunction

endpackage

`default_nettype wire

>>> rtl/sfbi_tap_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one horizontal tap: holds a sample of the row window and its weighted product
module sfbi_tap_cell (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      shift_en,
   input  wire logic                                      step_en,
   input  wire logic [sfbi_pkg::SAMPLE_W-1:0]             sample_in,
   input  wire logic signed [sfbi_pkg::TAP_W-1:0]         tap,
   output logic [sfbi_pkg::SAMPLE_W-1:0]                  sample_out,
   output logic signed [sfbi_pkg::HPROD_W-1:0]            product_out
);

   logic [sfbi_pkg::SAMPLE_W-1:0]        sample_ff;
   logic signed [sfbi_pkg::HPROD_W-1:0]  product_ff;
   logic signed [sfbi_pkg::HPROD_W-1:0]  product_in;
   logic signed [sfbi_pkg::HPROD_W-1:0]  tap_ext;
   logic signed [sfbi_pkg::HPROD_W-1:0]  sample_ext;

   always_comb begin
      tap_ext    = sfbi_pkg::HPROD_W'(tap);
      sample_ext = sfbi_pkg::HPROD_W'($signed({1'b0, sample_ff}));
      product_in = tap_ext * sample_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         product_ff <= product_in;
      end
   end

   assign sample_out  = sample_ff;
   assign product_out = product_ff;

endmodule

`default_nettype wire

>>> rtl/sfbi_line_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one vertical tap: a row-long line of horizontal results and the weighted product
module sfbi_line_cell (
   input  wire logic                                      clock,
   input  wire logic                                      shift_en,
   input  wire logic                                      step_en,
   input  wire logic signed [sfbi_pkg::HVAL_W-1:0]        data_in,
   input  wire logic signed [sfbi_pkg::TAP_W-1:0]         tap,
   output logic signed [sfbi_pkg::HVAL_W-1:0]             data_out,
   output logic signed [sfbi_pkg::VPROD_W-1:0]            product_out
);

   logic signed [sfbi_pkg::HVAL_W-1:0]   line_ff [sfbi_pkg::OUT_EDGE];
   logic signed [sfbi_pkg::VPROD_W-1:0]  product_ff;
   logic signed [sfbi_pkg::VPROD_W-1:0]  product_in;
   logic signed [sfbi_pkg::VPROD_W-1:0]  tap_ext;
   logic signed [sfbi_pkg::VPROD_W-1:0]  data_ext;

   always_comb begin
      tap_ext    = sfbi_pkg::VPROD_W'(tap);
      data_ext   = sfbi_pkg::VPROD_W'(data_in);
      product_in = tap_ext * data_ext;
   end

   // oldest entry leaves one row after it came in
   always_ff @(posedge clock) begin
      if (shift_en) begin
         line_ff[0] <= data_in;
         for (int i = 1; i < sfbi_pkg::OUT_EDGE; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         product_ff <= product_in;
      end
   end

   assign data_out    = line_ff[sfbi_pkg::OUT_EDGE-1];
   assign product_out = product_ff;

endmodule

`default_nettype wire

>>> rtl/separable_fir_block_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_sample
// rsp_      out        rsp_valid/rsp_stall  rsp_pixel, rsp_block_end
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// one sample word is accepted per cycle while req_stall is low; a pixel leaves after the sample
// that completes it, through a six-stage pipeline that advances as one.
// the pipeline holds only while a pixel waits at a stalled output and the next
// pixel has reached the vertical sum stage.
// reset clears the counters, the sample window, the stage flags and sets both
// coefficient registers to tap 3 = 64; the row lines are filled before use.
module separable_fir_block_interpolator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [sfbi_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [sfbi_pkg::PIX_W-1:0]                rsp_pixel,
   output logic                                      rsp_block_end,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sfbi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sfbi_pkg::COEF_W-1:0]          csr_data
);

   localparam int T = sfbi_pkg::TAPS;

   logic [sfbi_pkg::COEF_W-1:0]  h_coeffs_ff;
   logic [sfbi_pkg::COEF_W-1:0]  v_coeffs_ff;
   logic [sfbi_pkg::CNT_W-1:0]   col_count_ff;
   logic [sfbi_pkg::CNT_W-1:0]   row_count_ff;

   sfbi_pkg::sfbi_tag_type  tag_s1_ff, tag_s2_ff, tag_s3_ff, tag_s4_ff, tag_s5_ff, tag_s6_ff;
   sfbi_pkg::sfbi_tag_type  tag_s1_in;

   logic                                 step_en;
   logic                                 accept;

   logic [sfbi_pkg::SAMPLE_W-1:0]        hs [T+1];
   logic signed [sfbi_pkg::HPROD_W-1:0]  hprod [T];
   logic signed [sfbi_pkg::HSUM_W-1:0]   hsum_ff, hsum_in;
   logic signed [sfbi_pkg::HVAL_W-1:0]   hval_ff;

   logic signed [sfbi_pkg::HVAL_W-1:0]   vd [T+1];
   logic signed [sfbi_pkg::VPROD_W-1:0]  vprod [T];
   logic signed [sfbi_pkg::VSUM_W-1:0]   vsum_ff, vsum_in;

   logic                                 out_valid_ff, out_valid_in;
   logic [sfbi_pkg::PIX_W-1:0]           pixel_ff;
   logic                                 block_end_ff;

   // whole pipeline moves unless a pixel would overrun a stalled output word
   assign step_en   = !(out_valid_ff && rsp_stall && tag_s6_ff.out);
   assign accept    = req_valid && step_en;
   assign req_stall = !step_en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_coeffs_ff <= sfbi_pkg::COEF_RESET;
         v_coeffs_ff <= sfbi_pkg::COEF_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sfbi_pkg::CSR_H_COEFFS: h_coeffs_ff <= csr_data;
            sfbi_pkg::CSR_V_COEFFS: v_coeffs_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      tag_s1_in.hv   = accept && (col_count_ff >= sfbi_pkg::CNT_W'(T - 1));
      tag_s1_in.out  = tag_s1_in.hv && (row_count_ff >= sfbi_pkg::CNT_W'(T - 1));
      tag_s1_in.last = tag_s1_in.out && (row_count_ff == sfbi_pkg::CNT_W'(sfbi_pkg::EDGE - 1))
                       && (col_count_ff == sfbi_pkg::CNT_W'(sfbi_pkg::EDGE - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         if (col_count_ff == sfbi_pkg::CNT_W'(sfbi_pkg::EDGE - 1)) begin
            col_count_ff <= '0;
            if (row_count_ff == sfbi_pkg::CNT_W'(sfbi_pkg::EDGE - 1)) begin
               row_count_ff <= '0;
            end else begin
               row_count_ff <= row_count_ff + 1'b1;
            end
         end else begin
            col_count_ff <= col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_s1_ff <= '0;
         tag_s2_ff <= '0;
         tag_s3_ff <= '0;
         tag_s4_ff <= '0;
         tag_s5_ff <= '0;
         tag_s6_ff <= '0;
      end else if (step_en) begin
         tag_s1_ff <= tag_s1_in;
         tag_s2_ff <= tag_s1_ff;
         tag_s3_ff <= tag_s2_ff;
         tag_s4_ff <= tag_s3_ff;
         tag_s5_ff <= tag_s4_ff;
         tag_s6_ff <= tag_s5_ff;
      end
   end

   // horizontal window: newest sample enters at the top cell
   assign hs[T] = req_sample;

   for (genvar k = 0; k < T; k++) begin : g_tap
      sfbi_tap_cell u_tap (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (accept),
         .step_en     (step_en),
         .sample_in   (hs[k+1]),
         .tap         ($signed(h_coeffs_ff[8*k +: sfbi_pkg::TAP_W])),
         .sample_out  (hs[k]),
         .product_out (hprod[k])
      );
   end

   always_comb begin
      hsum_in = '0;
      for (int k = 0; k < T; k++) begin
         hsum_in = hsum_in + sfbi_pkg::HSUM_W'(hprod[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         hsum_ff <= hsum_in;
         hval_ff <= sfbi_pkg::sat_hval(hsum_ff);
      end
   end

   // vertical: cell j sees the result of j rows back in the same column
   assign vd[0] = hval_ff;

   for (genvar j = 0; j < T; j++) begin : g_line
      sfbi_line_cell u_line (
         .clock       (clock),
         .shift_en    (step_en && tag_s4_ff.hv),
         .step_en     (step_en),
         .data_in     (vd[j]),
         .tap         ($signed(v_coeffs_ff[8*(T-1-j) +: sfbi_pkg::TAP_W])),
         .data_out    (vd[j+1]),
         .product_out (vprod[j])
      );
   end

   always_comb begin
      vsum_in = '0;
      for (int j = 0; j < T; j++) begin
         vsum_in = vsum_in + sfbi_pkg::VSUM_W'(vprod[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         vsum_ff <= vsum_in;
      end
   end

   always_comb begin
      if (step_en && tag_s6_ff.out) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && tag_s6_ff.out) begin
         pixel_ff     <= sfbi_pkg::clamp_pix(vsum_ff);
         block_end_ff <= tag_s6_ff.last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel     = pixel_ff;
   assign rsp_block_end = block_end_ff;

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_stall && !(step_en && tag_s6_ff.out)) |=> !rsp_valid)
      else $error("pixel word shown again after it was taken");

   a_hold_sum: assert property (@(posedge clock) disable iff (reset)
      (tag_s6_ff.out && !step_en) |=> ($stable(vsum_ff) && tag_s6_ff.out))
      else $error("pending vertical sum lost while output stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (col_count_ff < sfbi_pkg::CNT_W'(sfbi_pkg::EDGE))
      && (row_count_ff < sfbi_pkg::CNT_W'(sfbi_pkg::EDGE)))
      else $error("block counters out of range");

   a_block_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && tag_s1_in.last) |=> (col_count_ff == '0 && row_count_ff == '0))
      else $error("counters did not wrap at block end");

   a_out_needs_hv: assert property (@(posedge clock) disable iff (reset)
      (tag_s4_ff.out || tag_s4_ff.last) |-> tag_s4_ff.hv)
      else $error("output flag without horizontal result");

endmodule

`default_nettype wire
